@@ hw/rtl/lud_pkg.sv @@
// ============================================================================
// lud_pkg
// Shared types and constants for the lenient UTF-8 decoder.
// ============================================================================
package lud_pkg;

    localparam int MAX_UNITS  = 4;
    localparam int PEND_DEPTH = 3;

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] CODE_CONT  = 8'h80;

    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [20:0] code_point;
        logic [31:0] unit_start;
        logic [2:0]  unit_bytes;
        logic        run_last;
        logic        text_end;
    } t_unit;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_ONE;
        if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            len = LEN_TWO;
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            len = LEN_THREE;
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

endpackage

@@ hw/rtl/lenient_utf8_decoder_unit.sv @@
// ============================================================================
// lenient_utf8_decoder_unit
// Lenient UTF-8 decoder: byte stream in, code units with offsets out.
// ============================================================================
// Slave stream: one text byte per word in tdata, tlast on the final byte.
// Master stream: one unit per word; tlast marks the last unit caused by one
// input byte, tuser marks the final unit of the text.
// A byte is decoded in the cycle it is taken; its units are held in a
// four-entry result register and leave one per cycle with the receiver ready,
// the first in the cycle after the byte is accepted. Sustained rate is one
// byte per cycle while each byte yields at most one unit and the receiver is
// ready; a byte with more units (broken sequence replay, up to four) holds
// the input until its last unit leaves. Bytes that only buffer yield no word.
// Reset clears the pending sequence and the offset counter; the offset also
// returns to zero after each final byte.
// When the receiver stalls, the held unit stays on the port and the input
// is taken only as the last held unit leaves.
// ============================================================================
module lenient_utf8_decoder_unit
    import lud_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,   // final_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // code_point[20:0], unit_start[52:21],
                                          // unit_bytes[55:53]
    output logic        o_m_axis_tlast,   // run_last
    output logic        o_m_axis_tuser    // text_end
);

    t_unit      units [MAX_UNITS];
    t_unit      out_unit;
    logic [2:0] count;
    logic       in_accept;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    lud_decode #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_accept),
        .i_byte  (i_s_axis_tdata),
        .i_fin   (i_s_axis_tlast),
        .o_units (units),
        .o_count (count)
    );

    lud_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_units     (units),
        .i_count     (count),
        .i_pop_ready (i_m_axis_tready),
        .o_ready     (o_s_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_unit      (out_unit)
    );

    assign o_m_axis_tdata = {out_unit.unit_bytes, out_unit.unit_start, out_unit.code_point};
    assign o_m_axis_tlast = out_unit.run_last;
    assign o_m_axis_tuser = out_unit.text_end;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("text end without run last");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_unit.unit_bytes >= LEN_ONE && out_unit.unit_bytes <= LEN_FOUR))
        else $error("unit length out of range");

    a_raw_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_unit.unit_bytes == LEN_ONE) |-> (out_unit.code_point[20:8] == 13'd0))
        else $error("raw unit wider than a byte");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> (count <= 3'(MAX_UNITS)))
        else $error("too many units for one byte");

endmodule

@@ hw/rtl/lud_decode.sv @@
// ============================================================================
// lud_decode
// Decoder state and single-pass unit builder: one byte in, up to four units.
// ============================================================================
module lud_decode
    import lud_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [7:0]  i_byte,
    input  logic        i_fin,
    output t_unit       o_units [MAX_UNITS],
    output logic [2:0]  o_count
);

    logic [7:0]             r_pend [PEND_DEPTH];
    logic [7:0]             n_pend [PEND_DEPTH];
    logic [1:0]             r_cnt, n_cnt;
    logic [2:0]             r_exp, n_exp;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_pstart, n_pstart;

    logic        is_open, is_cont, flush, has_last, last_full;
    logic [2:0]  len;
    logic [1:0]  flush_n;
    logic [20:0] full_cp;
    logic [63:0] pos_ext;
    logic [OFFSET_BITS-1:0] pend_off [PEND_DEPTH];
    logic [63:0] pend_ext [PEND_DEPTH];

    always_comb begin
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_exp    = r_exp;
        n_pstart = r_pstart;
        flush     = 1'b0;
        has_last  = 1'b0;
        last_full = 1'b0;
        len      = lead_length(i_byte);
        is_open  = (r_cnt != 2'd0) && (r_exp != LEN_ONE);
        is_cont  = (i_byte & MASK_CONT) == CODE_CONT;

        if (is_open && is_cont) begin
            if (({1'b0, r_cnt} + 3'd1) == r_exp) begin
                has_last  = 1'b1;
                last_full = 1'b1;
                n_cnt     = 2'd0;
                n_exp     = LEN_ONE;
            end else if (i_fin) begin
                flush    = 1'b1;
                has_last = 1'b1;
            end else begin
                n_pend[r_cnt] = i_byte;
                n_cnt         = r_cnt + 2'd1;
            end
        end else begin
            flush = is_open;
            n_cnt = 2'd0;
            n_exp = LEN_ONE;
            if (len != LEN_ONE && !i_fin) begin
                n_pend[0] = i_byte;
                n_cnt     = 2'd1;
                n_exp     = len;
                n_pstart  = r_pos;
            end else begin
                has_last = 1'b1;
            end
        end

        if (i_fin) begin
            n_cnt = 2'd0;
            n_exp = LEN_ONE;
            n_pos = '0;
        end else begin
            n_pos = r_pos + OFFSET_BITS'(1);
        end
    end

    always_comb begin
        unique case (r_exp)
            LEN_TWO:   full_cp = {10'd0, r_pend[0][4:0], i_byte[5:0]};
            LEN_THREE: full_cp = {5'd0, r_pend[0][3:0], r_pend[1][5:0], i_byte[5:0]};
            default:   full_cp = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0],
                                  i_byte[5:0]};
        endcase
    end

    assign flush_n = flush ? r_cnt : 2'd0;
    assign o_count = {1'b0, flush_n} + {2'd0, has_last};
    assign pos_ext = 64'(r_pos);

    always_comb begin
        for (int k = 0; k < PEND_DEPTH; k++) begin
            pend_off[k] = r_pstart + OFFSET_BITS'(k);
            pend_ext[k] = 64'(pend_off[k]);
        end
        for (int k = 0; k < MAX_UNITS; k++) begin
            o_units[k] = '0;
            if (k < PEND_DEPTH && 2'(k) < flush_n) begin
                o_units[k].code_point = {13'd0, r_pend[k[1:0]]};
                o_units[k].unit_start = pend_ext[k[1:0]][31:0];
                o_units[k].unit_bytes = LEN_ONE;
            end else if (3'(k) == {1'b0, flush_n}) begin
                o_units[k].code_point = last_full ? full_cp : {13'd0, i_byte};
                o_units[k].unit_start = last_full ? pend_ext[0][31:0] : pos_ext[31:0];
                o_units[k].unit_bytes = last_full ? r_exp : LEN_ONE;
            end
            o_units[k].run_last = (3'(k) + 3'd1) == o_count;
            o_units[k].text_end = ((3'(k) + 3'd1) == o_count) && i_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_exp    <= LEN_ONE;
            r_pos    <= '0;
            r_pstart <= '0;
        end else if (i_load) begin
            r_cnt    <= n_cnt;
            r_exp    <= n_exp;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pend <= n_pend;
        end
    end

endmodule

@@ hw/rtl/lud_result_queue.sv @@
// ============================================================================
// lud_result_queue
// Result register: holds the units of one byte and hands them out in order.
// ============================================================================
module lud_result_queue
    import lud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_unit       i_units [MAX_UNITS],
    input  logic [2:0]  i_count,
    input  logic        i_pop_ready,
    output logic        o_ready,
    output logic        o_valid,
    output t_unit       o_unit
);

    t_unit      r_q [MAX_UNITS];
    logic [2:0] r_cnt;
    logic       pop;

    assign o_valid = r_cnt != 3'd0;
    assign o_unit  = r_q[0];
    assign pop     = o_valid && i_pop_ready;
    // free when empty or once the last held word leaves this cycle
    assign o_ready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_pop_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_count;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_units;
        end else if (pop) begin
            for (int k = 0; k < MAX_UNITS - 1; k++) begin
                r_q[k] <= r_q[k+1];
            end
        end
    end

endmodule
